// File: rtl/asp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and constants for the affine state propagation block.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;

    localparam logic [1:0] ACT_LOAD_X0     = 2'd0;
    localparam logic [1:0] ACT_LOAD_B      = 2'd1;
    localparam logic [1:0] ACT_LOAD_A      = 2'd2;
    localparam logic [1:0] ACT_PROPAGATE   = 2'd3;

    typedef struct packed {
        logic x0_we;
        logic b_we;
        logic rotate;
        logic new_we;
        logic commit;
    } asp_cell_ctrl_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } asp_tag_t;

endpackage

// File: rtl/affine_state_propagation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_state_propagation
// Stage-by-stage propagation g = A*g + b of a running state vector, Q16.16.
// ----------------------------------------------------------------------------
// Load words (initial state, offset, matrix element) are written directly while idle.
// A propagate word runs n*n multiply-accumulates through one shared MAC, one
// per cycle, while the state elements circulate through a ring of cells, then
// drains the pipeline and commits, then emits n words, one per cycle when
// m_ready is high.
// n is state_size capped at MAX_STATES; a size of zero gives no output words.
// Matrix and offset entries must be written before a propagate reads them.
// A new word is taken only after the previous propagate has handed its last
// result to the output register.
// ----------------------------------------------------------------------------
module affine_state_propagation
    import asp_pkg::*;
#(
    parameter int MAX_STATES = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [3:0]               cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic [2:0]               s_row,
    input  logic [2:0]               s_col,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_index,
    output logic signed [DATA_W-1:0] m_state_value,
    output logic                     m_last
);

    localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CNT_W = $clog2(MAX_STATES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [3:0]               state_size_reg;
    logic [IDX_W-1:0]         r_reg;
    logic [IDX_W-1:0]         c_reg;
    logic [IDX_W-1:0]         e_idx_reg;
    logic [IDX_W-1:0]         last_idx_reg;
    logic                     m_valid_reg;
    logic [2:0]               m_index_reg;
    logic signed [DATA_W-1:0] m_value_reg;
    logic                     m_last_reg;

    logic                     s_accept;
    logic [CNT_W-1:0]         n_sel;

    asp_cell_ctrl_t           cell_ctrl [MAX_STATES];
    logic signed [DATA_W-1:0] cur_vals  [MAX_STATES];
    logic signed [DATA_W-1:0] b_vals    [MAX_STATES];
    logic signed [DATA_W-1:0] shift_vals [MAX_STATES];

    asp_tag_t                 iss_tag;
    logic                     mat_we;
    logic                     res_valid;
    logic [IDX_W-1:0]         res_row;
    logic signed [DATA_W-1:0] res_value;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        if (32'(state_size_reg) > MAX_STATES) begin
            n_sel = CNT_W'(MAX_STATES);
        end else begin
            n_sel = CNT_W'(state_size_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_size_reg <= 4'd8;
        end else if (cfg_we) begin
            state_size_reg <= cfg_wdata;
        end
    end

    // ring of state cells
    for (genvar i = 0; i < MAX_STATES; i++) begin : g_cell
        assign cell_ctrl[i] = '{
            x0_we:  s_accept && (s_action == ACT_LOAD_X0) && (32'(s_col) == i),
            b_we:   s_accept && (s_action == ACT_LOAD_B) && (32'(s_row) == i),
            rotate: (state_reg == ST_RUN) && (IDX_W'(i) <= last_idx_reg),
            new_we: res_valid && (res_row == IDX_W'(i)),
            commit: (state_reg == ST_COMMIT) && (IDX_W'(i) <= last_idx_reg)
        };

        if (i == MAX_STATES - 1) begin : g_tail
            assign shift_vals[i] = cur_vals[0];
        end else begin : g_mid
            assign shift_vals[i] = (IDX_W'(i) == last_idx_reg) ? cur_vals[0]
                                                                : cur_vals[i+1];
        end

        asp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl[i]),
            .wr_value  (s_value),
            .shift_in  (shift_vals[i]),
            .new_value (res_value),
            .cur_value (cur_vals[i]),
            .b_value   (b_vals[i])
        );
    end

    assign mat_we = s_accept && (s_action == ACT_LOAD_A)
                    && (32'(s_row) < MAX_STATES) && (32'(s_col) < MAX_STATES);

    assign iss_tag = '{
        valid: (state_reg == ST_RUN),
        first: (c_reg == '0),
        last:  (c_reg == last_idx_reg)
    };

    asp_mac #(
        .MAX_STATES (MAX_STATES)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (mat_we),
        .wr_row    (IDX_W'(s_row)),
        .wr_col    (IDX_W'(s_col)),
        .wr_data   (s_value),
        .iss_tag   (iss_tag),
        .iss_row   (r_reg),
        .iss_col   (c_reg),
        .iss_g     (cur_vals[0]),
        .iss_b     (b_vals[r_reg]),
        .res_valid (res_valid),
        .res_row   (res_row),
        .res_value (res_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            r_reg        <= '0;
            c_reg        <= '0;
            e_idx_reg    <= '0;
            last_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_index_reg  <= '0;
            m_value_reg  <= '0;
            m_last_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_action == ACT_PROPAGATE) && (n_sel != '0)) begin
                        last_idx_reg <= IDX_W'(n_sel - CNT_W'(1));
                        r_reg        <= '0;
                        c_reg        <= '0;
                        state_reg    <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (c_reg == last_idx_reg) begin
                        c_reg <= '0;
                        if (r_reg == last_idx_reg) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            r_reg <= r_reg + IDX_W'(1);
                        end
                    end else begin
                        c_reg <= c_reg + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (res_valid && (res_row == last_idx_reg)) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    e_idx_reg <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_index_reg <= 3'(e_idx_reg);
                        m_value_reg <= cur_vals[e_idx_reg];
                        m_last_reg  <= (e_idx_reg == last_idx_reg);
                        if (e_idx_reg == last_idx_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            e_idx_reg <= e_idx_reg + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_index       = m_index_reg;
    assign m_state_value = m_value_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // mac results only come back while a propagate is in flight
    a_res_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("mac result outside a propagate step");

    // commit follows the final row result
    a_commit_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMMIT) |-> ($past(res_valid) && $past(res_row) == last_idx_reg))
        else $error("commit without final row result");

    // sequencer stays inside the active size
    a_seq_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (r_reg <= last_idx_reg && c_reg <= last_idx_reg))
        else $error("sequencer index beyond state size");

    // no word is taken while a step is in progress
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN || state_reg == ST_DRAIN) |=> !s_ready || $past(state_reg == ST_DRAIN))
        else $error("input ready during propagate");
`endif

endmodule

// File: rtl/asp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_cell
// One element of the state chain: running value, offset and next value.
// ----------------------------------------------------------------------------
module asp_cell
    import asp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  asp_cell_ctrl_t           ctrl,
    input  logic signed [DATA_W-1:0] wr_value,
    input  logic signed [DATA_W-1:0] shift_in,
    input  logic signed [DATA_W-1:0] new_value,
    output logic signed [DATA_W-1:0] cur_value,
    output logic signed [DATA_W-1:0] b_value
);

    logic signed [DATA_W-1:0] cur_reg;
    logic signed [DATA_W-1:0] cur_next;
    logic signed [DATA_W-1:0] b_reg;
    logic signed [DATA_W-1:0] new_reg;

    always_comb begin
        cur_next = cur_reg;
        if (ctrl.x0_we) begin
            cur_next = wr_value;
        end else if (ctrl.rotate) begin
            cur_next = shift_in;
        end else if (ctrl.commit) begin
            cur_next = new_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.b_we) begin
            b_reg <= wr_value;
        end
        if (ctrl.new_we) begin
            new_reg <= new_value;
        end
    end

    assign cur_value = cur_reg;
    assign b_value   = b_reg;

endmodule

// File: rtl/asp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_mac
// Stage matrix memory and the shared Q16.16 multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module asp_mac
    import asp_pkg::*;
#(
    parameter int MAX_STATES = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   wr_en,
    input  logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] wr_row,
    input  logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] wr_col,
    input  logic signed [DATA_W-1:0]               wr_data,
    input  asp_tag_t                               iss_tag,
    input  logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] iss_row,
    input  logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] iss_col,
    input  logic signed [DATA_W-1:0]               iss_g,
    input  logic signed [DATA_W-1:0]               iss_b,
    output logic                                   res_valid,
    output logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] res_row,
    output logic signed [DATA_W-1:0]               res_value
);

    localparam int IDX_W  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int SUM_W  = TERM_W + 1;

    logic signed [DATA_W-1:0] mem [MAX_STATES][MAX_STATES];

    asp_tag_t                 tag_s1;
    logic [IDX_W-1:0]         row_s1;
    logic signed [DATA_W-1:0] a_s1;
    logic signed [DATA_W-1:0] g_s1;
    logic signed [DATA_W-1:0] b_s1;

    asp_tag_t                 tag_s2;
    logic [IDX_W-1:0]         row_s2;
    logic signed [PROD_W-1:0] prod_s2;
    logic signed [DATA_W-1:0] b_s2;

    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] acc_next;
    logic signed [DATA_W-1:0] base;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;

    logic                     res_valid_reg;
    logic [IDX_W-1:0]         res_row_reg;
    logic signed [DATA_W-1:0] res_value_reg;

    // matrix memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_col] <= wr_data;
        end
        a_s1 <= mem[iss_row][iss_col];
    end

    always_ff @(posedge aclk) begin
        row_s1  <= iss_row;
        g_s1    <= iss_g;
        b_s1    <= iss_b;
        row_s2  <= row_s1;
        prod_s2 <= a_s1 * g_s1;
        b_s2    <= b_s1;
        acc_reg <= acc_next;
        res_row_reg   <= row_s2;
        res_value_reg <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_s1        <= '0;
            tag_s2        <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            tag_s1        <= iss_tag;
            tag_s2        <= tag_s1;
            res_valid_reg <= tag_s2.valid && tag_s2.last;
        end
    end

    // floor of the product, then saturating add
    assign term = prod_s2[PROD_W-1:FRAC_W];
    assign base = tag_s2.first ? b_s2 : acc_reg;
    assign sum  = SUM_W'(base) + SUM_W'(term);

    always_comb begin
        if (sum > SUM_W'(Q_MAX)) begin
            acc_next = Q_MAX;
        end else if (sum < SUM_W'(Q_MIN)) begin
            acc_next = Q_MIN;
        end else begin
            acc_next = sum[DATA_W-1:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_row   = res_row_reg;
    assign res_value = res_value_reg;

endmodule
